### rtl/mcpwm_pkg.sv
// Shared types and constants for the multi-channel PWM generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mcpwm_pkg;

  localparam int SLOTS = 8;
  localparam int CNT_W = 8;
  localparam int PCT_W = 8;
  localparam int CH_W  = 4;

  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_SET_DUTY = 1'b1;

  typedef logic [CNT_W-1:0] cmp_t;
  typedef logic [PCT_W-1:0] pct_t;

  typedef struct packed {
    logic [SLOTS-1:0] pwm_bits;
    logic             period_start;
  } pwm_result_t;

endpackage

`default_nettype wire

### rtl/multi_channel_pwm_shadowed_core.sv
// Top level of the multi-channel PWM generator with shadowed duty registers.
// Instantiates mcpwm_scale and mcpwm_outq; depends on mcpwm_pkg.
//
// Requests arrive on the input channel (in_valid, in_stall, kind, channel,
// duty_percent). A tick request advances the period counter, which wraps to
// zero after it reaches PERIOD_TOP, and yields one result on the output
// channel (out_valid, out_stall, pwm_bits, period_start). A set-duty request
// writes the scaled compare value into the channel's shadow register and
// yields no result; a channel at or above CHANNELS is ignored. Shadow values
// move to the active compare registers at the next wrap.
// Every request is handled in the cycle it is accepted; a tick's result
// lands in the output or skid register. One request per cycle unless stalled.
// The output register and a skid stage hold up to two results; when the
// receiver stalls and both are full, in_stall rises until the head is taken.
// Reset clears the counter, all compare registers, the pending flag and the
// result buffer; the block takes requests in the first cycle after reset.
`default_nettype none

module multi_channel_pwm_shadowed_core
  import mcpwm_pkg::*;
#(
  parameter int CHANNELS   = 8,
  parameter int PERIOD_TOP = 255,
  parameter int FULL_SCALE = 100
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             kind,
  input  wire logic [CH_W-1:0]  channel,
  input  wire logic [PCT_W-1:0] duty_percent,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [SLOTS-1:0]      pwm_bits,
  output logic                  period_start
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cmp_t        tick_counter;
  cmp_t        tick_counter_next;
  cmp_t        shadow_compare [CHANNELS];
  cmp_t        active_compare [CHANNELS];
  cmp_t        active_view    [CHANNELS];
  logic        update_pending;
  logic        accept;
  logic        do_tick;
  logic        do_set;
  logic        wrap;
  logic        full;
  cmp_t        scaled;
  logic [SLOTS-1:0] bits;
  pwm_result_t result;
  pwm_result_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign do_tick  = accept && (kind == KIND_TICK);
  assign do_set   = accept && (kind == KIND_SET_DUTY) && (channel < CH_W'(CHANNELS));

  mcpwm_scale #(
    .PERIOD_TOP (PERIOD_TOP),
    .FULL_SCALE (FULL_SCALE)
  ) u_scale (
    .duty_percent (duty_percent),
    .compare      (scaled)
  );

  assign wrap              = tick_counter >= cmp_t'(PERIOD_TOP);
  assign tick_counter_next = wrap ? '0 : tick_counter + cmp_t'(1);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_view
    assign active_view[i] = (wrap && update_pending) ? shadow_compare[i] : active_compare[i];
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_bits
    if (i < CHANNELS) begin : g_used
      assign bits[i] = tick_counter_next < active_view[i];
    end else begin : g_unused
      assign bits[i] = 1'b0;
    end
  end

  assign result.pwm_bits     = bits;
  assign result.period_start = wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      update_pending <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        shadow_compare[i] <= '0;
        active_compare[i] <= '0;
      end
    end else if (do_tick) begin
      tick_counter <= tick_counter_next;
      if (wrap && update_pending) begin
        update_pending <= 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
          active_compare[i] <= shadow_compare[i];
        end
      end
    end else if (do_set) begin
      shadow_compare[channel[IDX_W-1:0]] <= scaled;
      update_pending                     <= 1'b1;
    end
  end

  mcpwm_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (do_tick),
    .push_data  (result),
    .full       (full),
    .head_valid (out_valid),
    .head       (head),
    .head_stall (out_stall)
  );

  assign pwm_bits     = head.pwm_bits;
  assign period_start = head.period_start;

endmodule

`default_nettype wire

### rtl/mcpwm_scale.sv
// Duty scaling: clamps a percentage to full scale and maps it to a compare value.
// A constant table built at elaboration; depends on mcpwm_pkg.
`default_nettype none

module mcpwm_scale
  import mcpwm_pkg::*;
#(
  parameter int PERIOD_TOP = 255,
  parameter int FULL_SCALE = 100
) (
  input  pct_t duty_percent,
  output cmp_t compare
);

  localparam int ENTRIES = 2 ** PCT_W;

  cmp_t scale_rom [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    localparam int CLAMPED = (g > FULL_SCALE) ? FULL_SCALE : g;
    localparam int SCALED  = (CLAMPED * PERIOD_TOP) / FULL_SCALE;
    assign scale_rom[g] = cmp_t'(SCALED);
  end

  assign compare = scale_rom[duty_percent];

endmodule

`default_nettype wire

### rtl/mcpwm_outq.sv
// Two-entry result buffer: an output register with a skid stage behind it.
// Lets a new request in while a finished result waits; depends on mcpwm_pkg.
`default_nettype none

module mcpwm_outq
  import mcpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pwm_result_t push_data,
  output logic        full,
  output logic        head_valid,
  output pwm_result_t head,
  input  logic        head_stall
);

  logic        skid_valid;
  pwm_result_t skid;
  logic        pop;

  assign pop  = head_valid && !head_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end else begin
        head       <= push_data;
        head_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### dv/multi_channel_pwm_shadowed_core_tb.sv
// Self-checking testbench for multi_channel_pwm_shadowed_core: queued tick and set-duty
// requests feed a driver, a monitor checks every result against an internal PWM predictor.
// Depends on mcpwm_pkg and the core RTL only.
module multi_channel_pwm_shadowed_core_tb;
  import mcpwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS   = 8;
  localparam int PERIOD_TOP = 255;
  localparam int FULL_SCALE = 100;

  typedef struct {
    logic            kind;
    logic [CH_W-1:0] ch;
    pct_t            pct;
  } duty_req_t;

  logic             clk;
  logic             rst;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             kind = KIND_TICK;
  logic [CH_W-1:0]  channel = '0;
  logic [PCT_W-1:0] duty_percent = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SLOTS-1:0] pwm_bits;
  logic             period_start;

  duty_req_t   req_q[$];
  pwm_result_t pwm_expected[$];

  cmp_t duty_shadow [SLOTS] = '{default: '0};
  cmp_t duty_active [SLOTS] = '{default: '0};
  cmp_t period_count = '0;
  bit   swap_pending = 1'b0;

  int idle_pct = 30;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int ticks_taken = 0;
  int duty_writes = 0;
  int ignored_writes = 0;
  int wraps_seen = 0;
  int results_checked = 0;

  multi_channel_pwm_shadowed_core #(
    .CHANNELS  (CHANNELS),
    .PERIOD_TOP(PERIOD_TOP),
    .FULL_SCALE(FULL_SCALE)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .channel     (channel),
    .duty_percent(duty_percent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_bits    (pwm_bits),
    .period_start(period_start)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  task automatic pwm_advance(input duty_req_t r);
    pwm_result_t res;
    int          pct;
    if (r.kind == KIND_SET_DUTY) begin
      if (r.ch < CHANNELS) begin
        pct = (r.pct > FULL_SCALE) ? FULL_SCALE : int'(r.pct);
        duty_shadow[r.ch] = cmp_t'(pct * PERIOD_TOP / FULL_SCALE);
        swap_pending = 1'b1;
        duty_writes++;
      end else begin
        ignored_writes++;
      end
    end else begin
      res.period_start = (period_count >= PERIOD_TOP);
      if (res.period_start) begin
        period_count = '0;
        wraps_seen++;
        if (swap_pending) begin
          duty_active = duty_shadow;
          swap_pending = 1'b0;
        end
      end else begin
        period_count = period_count + 1'b1;
      end
      res.pwm_bits = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        if (period_count < duty_active[i]) begin
          res.pwm_bits[i] = 1'b1;
        end
      end
      pwm_expected.push_back(res);
      ticks_taken++;
    end
  endtask

  always @(posedge clk) begin : driver
    duty_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.kind = kind;
        r.ch   = channel;
        r.pct  = duty_percent;
        pwm_advance(r);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          kind         <= r.kind;
          channel      <= r.ch;
          duty_percent <= r.pct;
          in_valid     <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pwm_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pwm_expected.size() == 0) begin
          note_mismatch("result with nothing outstanding", pwm_bits, 0);
        end else begin
          want = pwm_expected.pop_front();
          results_checked++;
          if (pwm_bits !== want.pwm_bits) begin
            note_mismatch("pwm_bits", pwm_bits, want.pwm_bits);
          end
          if (period_start !== want.period_start) begin
            note_mismatch("period_start", period_start, want.period_start);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_left = pick_gap();
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic queue_duty(input int ch, input int pct);
    duty_req_t r;
    r.kind = KIND_SET_DUTY;
    r.ch   = ch[CH_W-1:0];
    r.pct  = pct[PCT_W-1:0];
    req_q.push_back(r);
  endtask

  task automatic queue_ticks(input int n);
    duty_req_t r;
    r.kind = KIND_TICK;
    repeat (n) begin
      r.ch  = CH_W'($urandom_range(15));
      r.pct = PCT_W'($urandom_range(255));
      req_q.push_back(r);
    end
  endtask

  // Mostly ticks so that several full periods pass, with duty updates scattered in.
  task automatic queue_random(input int n);
    int ch;
    int pct;
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        ch = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(CHANNELS - 1);
        case ($urandom_range(3))
          0: pct = 0;
          1: pct = FULL_SCALE;
          2: pct = $urandom_range(255, FULL_SCALE + 1);
          default: pct = $urandom_range(255);
        endcase
        queue_duty(ch, pct);
      end else begin
        queue_ticks(1);
      end
    end
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || pwm_expected.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    idle_pct = 30;
    queue_ticks(2);
    queue_duty(0, 0);
    queue_duty(1, FULL_SCALE);
    queue_duty(2, FULL_SCALE + 1);
    queue_duty(3, 255);
    queue_duty(4, 1);
    queue_duty(5, FULL_SCALE - 1);
    queue_duty(6, 50);
    queue_duty(7, FULL_SCALE);
    queue_duty(CHANNELS, 77);
    queue_duty(15, 255);
    queue_ticks(3);
    wait_drained();

    idle_pct = 0;
    queue_random(380);
    wait_drained();
    idle_pct = 45;
    queue_random(380);
    wait_drained();
    idle_pct = 15;
    queue_random(380);
    wait_drained();

    repeat (20) @(negedge clk);
    if (pwm_expected.size() > 0) begin
      note_mismatch("results never delivered", 0, pwm_expected.size());
    end
    $display("Covered %0d ticks over %0d period wraps, %0d duty writes and %0d ignored writes.",
             ticks_taken, wraps_seen, duty_writes, ignored_writes);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("multi_channel_pwm_shadowed_core_tb: done, clean");
    end else begin
      $display("multi_channel_pwm_shadowed_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("multi_channel_pwm_shadowed_core_tb: done, errors");
    $finish;
  end

endmodule
